[rtl/rtt_pkg.sv]
// Shared types and constants of the retransmission timeout table.
package rtt_pkg;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_ACK     = 2'd2;

  localparam logic [2:0] KIND_ENQUEUED   = 3'd0;
  localparam logic [2:0] KIND_REFUSED    = 3'd1;
  localparam logic [2:0] KIND_RESEND     = 3'd2;
  localparam logic [2:0] KIND_TICK_DONE  = 3'd3;
  localparam logic [2:0] KIND_ACK_HIT    = 3'd4;
  localparam logic [2:0] KIND_ACK_MISS   = 3'd5;

  localparam logic [15:0] TIMER_SAT = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] message_handle;
    logic [7:0]  timeout_factor;
    logic [15:0] elapsed_ms;
    logic [15:0] round_trip_ms;
    logic [15:0] acked_sequence;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] resend_handle;
    logic [15:0] resend_sequence;
    logic [5:0]  pending_count;
    logic        last;
  } out_word_t;

endpackage

[rtl/retransmit_timer_table_unit.sv]
// Top level of the retransmission timeout table.
//
//   channel | handshake        | word
//   input   | push_i / full_o  | in_word_i  (rtt_pkg::in_word_t)
//   result  | pop_i / empty_o  | out_word_o (rtt_pkg::out_word_t)
//
// An enqueue or an unknown operation passes the input register and then the
// result register before its word shows; an ack searches one entry per cycle.
// A tick takes one step per held entry, removals included, and one for the
// tick-done word, and each step waits while a word waits for pop_i; the next
// word is taken in the cycle after the last one leaves. Reset clears the state,
// the entry count, the sequence counter and the valid flags, not the table.
module retransmit_timer_table_unit #(
  parameter int ENTRIES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  rtt_pkg::in_word_t   in_word_i,
  output logic                empty_o,
  input  logic                pop_i,
  output rtt_pkg::out_word_t  out_word_o
);

  logic              cmd_valid, cmd_take, res_valid;
  rtt_pkg::in_word_t cmd;

  rtt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_o       (cmd)
  );

  rtt_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_take_i  (pop_i),
    .res_o       (out_word_o)
  );

  assign empty_o = !res_valid;

endmodule

[rtl/rtt_front.sv]
// Input stage: registers one word and presents it to the table engine.
module rtt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  rtt_pkg::in_word_t in_word_i,
  output logic              cmd_valid_o,
  input  logic              cmd_take_i,
  output rtt_pkg::in_word_t cmd_o
);

  logic              valid_q, valid_d;
  rtt_pkg::in_word_t word_q, word_d;

  assign full_o      = valid_q;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = word_q;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (cmd_take_i) begin
      valid_d = 1'b0;
    end
    if (push_i && !valid_q) begin
      valid_d = 1'b1;
      word_d  = in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

[rtl/rtt_engine.sv]
// Table engine: holds the entries and walks them one per cycle, where a tick step waits while the result slot is full.
module rtt_engine #(
  parameter int ENTRIES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_take_o,
  input  rtt_pkg::in_word_t  cmd_i,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output rtt_pkg::out_word_t res_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TICK = 2'd1;
  localparam logic [1:0] ST_ACK  = 2'd2;

  logic [15:0] handle_q [ENTRIES];
  logic [15:0] elapsed_q [ENTRIES];
  logic [7:0]  factor_q [ENTRIES];
  logic [15:0] seq_q [ENTRIES];
  logic        acked_q [ENTRIES];
  logic        sent_q [ENTRIES];

  logic [1:0]  state_q, state_d;
  logic [5:0]  count_q, count_d;
  logic [15:0] nseq_q, nseq_d;
  logic [5:0]  idx_q, idx_d;
  logic        res_valid_q, res_valid_d;
  rtt_pkg::out_word_t res_q, res_d;
  rtt_pkg::in_word_t  cmd_q, cmd_d;

  logic [IW-1:0] idx;
  logic [IW-1:0] tail;
  logic [19:0]   lhs;
  logic [23:0]   rhs;
  logic [16:0]   sum;
  logic          wr_ent, wr_move, wr_new, set_ack;

  assign idx  = idx_q[IW-1:0];
  assign tail = IW'(count_q - 6'd1);
  assign lhs  = {elapsed_q[idx], 4'd0};
  assign rhs  = cmd_q.round_trip_ms * factor_q[idx];

  assign cmd_take_o  = cmd_valid_i && (state_q == ST_IDLE) && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    nseq_d      = nseq_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_take_i;
    wr_ent      = 1'b0;
    wr_move     = 1'b0;
    wr_new      = 1'b0;
    set_ack     = 1'b0;
    sum         = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_take_o) begin
          cmd_d = cmd_i;
          idx_d = '0;
          res_d = '0;
          res_d.last = 1'b1;
          res_d.pending_count = count_q;
          if (cmd_i.operation == rtt_pkg::OP_ENQUEUE) begin
            res_valid_d = 1'b1;
            if (32'(count_q) >= ENTRIES) begin
              res_d.kind = rtt_pkg::KIND_REFUSED;
            end else begin
              wr_new = 1'b1;
              count_d = count_q + 6'd1;
              res_d.kind = rtt_pkg::KIND_ENQUEUED;
              res_d.pending_count = count_q + 6'd1;
            end
          end else if (cmd_i.operation == rtt_pkg::OP_ACK) begin
            state_d = ST_ACK;
          end else if (cmd_i.operation == rtt_pkg::OP_TICK && cmd_i.round_trip_ms != '0) begin
            state_d = ST_TICK;
          end else begin
            res_valid_d = 1'b1;
            res_d.kind = rtt_pkg::KIND_TICK_DONE;
          end
        end
      end
      ST_ACK: begin
        if (idx_q >= count_q) begin
          res_valid_d = 1'b1;
          res_d.kind = rtt_pkg::KIND_ACK_MISS;
          state_d = ST_IDLE;
        end else if (sent_q[idx] && seq_q[idx] == cmd_q.acked_sequence) begin
          set_ack = 1'b1;
          res_valid_d = 1'b1;
          res_d.kind = rtt_pkg::KIND_ACK_HIT;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_TICK: begin
        // Each step waits until the result slot is free, since it may emit.
        if (!res_valid_q || res_take_i) begin
          res_d = '0;
          res_d.pending_count = count_q;
          if (idx_q >= count_q) begin
            res_valid_d = 1'b1;
            res_d.kind = rtt_pkg::KIND_TICK_DONE;
            res_d.last = 1'b1;
            state_d = ST_IDLE;
          end else if (24'(lhs) > rhs) begin
            wr_ent = 1'b1;
            sum = {1'b0, cmd_q.elapsed_ms};
            nseq_d = nseq_q + 16'd1;
            res_valid_d = 1'b1;
            res_d.kind = rtt_pkg::KIND_RESEND;
            res_d.resend_handle = handle_q[idx];
            res_d.resend_sequence = nseq_q;
            idx_d = idx_q + 6'd1;
          end else if (acked_q[idx]) begin
            wr_move = 1'b1;
            count_d = count_q - 6'd1;
          end else begin
            wr_ent = 1'b1;
            sum = {1'b0, elapsed_q[idx]} + {1'b0, cmd_q.elapsed_ms};
            idx_d = idx_q + 6'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_new) begin
      handle_q[count_q[IW-1:0]]  <= cmd_i.message_handle;
      elapsed_q[count_q[IW-1:0]] <= rtt_pkg::TIMER_SAT;
      factor_q[count_q[IW-1:0]]  <= cmd_i.timeout_factor;
      seq_q[count_q[IW-1:0]]     <= '0;
      acked_q[count_q[IW-1:0]]   <= 1'b0;
      sent_q[count_q[IW-1:0]]    <= 1'b0;
    end
    if (set_ack) begin
      acked_q[idx] <= 1'b1;
    end
    if (wr_move) begin
      handle_q[idx]  <= handle_q[tail];
      elapsed_q[idx] <= elapsed_q[tail];
      factor_q[idx]  <= factor_q[tail];
      seq_q[idx]     <= seq_q[tail];
      acked_q[idx]   <= acked_q[tail];
      sent_q[idx]    <= sent_q[tail];
    end
    if (wr_ent) begin
      elapsed_q[idx] <= sum[16] ? rtt_pkg::TIMER_SAT : sum[15:0];
      if (res_d.kind == rtt_pkg::KIND_RESEND) begin
        seq_q[idx]   <= nseq_q;
        sent_q[idx]  <= 1'b1;
        acked_q[idx] <= 1'b0;
      end
    end
    cmd_q <= cmd_d;
    res_q <= res_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      nseq_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      nseq_q      <= nseq_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

[sim/retransmit_timer_table_unit_test.sv]
// Self-checking testbench of the retransmission timeout table.
`timescale 1ns / 100ps

module retransmit_timer_table_unit_test;

  localparam int ENTRIES = 32;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_WORDS = 500;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic pop_i = 1'b0;
  logic full_o;
  logic empty_o;
  rtt_pkg::in_word_t in_word_i = '0;
  rtt_pkg::out_word_t out_word_o;

  retransmit_timer_table_unit #(.ENTRIES(ENTRIES)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push_i), .full_o(full_o),
    .in_word_i(in_word_i), .empty_o(empty_o), .pop_i(pop_i), .out_word_o(out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The predictor keeps its own copy of the table. Entries are only read below
  // the current count, so nothing needs clearing at reset.
  logic [15:0] tbl_handle [ENTRIES];
  logic [15:0] tbl_elapsed [ENTRIES];
  logic [7:0]  tbl_factor [ENTRIES];
  logic [15:0] tbl_sequence [ENTRIES];
  logic        tbl_acked [ENTRIES];
  logic        tbl_sent [ENTRIES];
  int          tbl_count = 0;
  logic [15:0] seq_counter = '0;

  rtt_pkg::out_word_t expected_words [$];
  int failures = 0;
  int idle_cycles = 0;
  bit sender_done = 1'b0;

  // Appends one expected word; the count field reflects the table after it.
  function automatic void note_word(logic [2:0] kind, logic [15:0] handle,
                                    logic [15:0] seq);
    rtt_pkg::out_word_t w;
    w.kind = kind;
    w.resend_handle = handle;
    w.resend_sequence = seq;
    w.pending_count = 6'(tbl_count);
    w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  // Applies one input word to the predicted table and queues what it causes.
  function automatic void predict_table(rtt_pkg::in_word_t w);
    int i;
    bit hit;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [16:0] sum;
    hit = 1'b0;
    if (w.operation == rtt_pkg::OP_ENQUEUE) begin
      if (tbl_count >= ENTRIES) begin
        note_word(rtt_pkg::KIND_REFUSED, '0, '0);
      end else begin
        tbl_handle[tbl_count] = w.message_handle;
        tbl_elapsed[tbl_count] = rtt_pkg::TIMER_SAT;
        tbl_factor[tbl_count] = w.timeout_factor;
        tbl_sequence[tbl_count] = '0;
        tbl_acked[tbl_count] = 1'b0;
        tbl_sent[tbl_count] = 1'b0;
        tbl_count++;
        note_word(rtt_pkg::KIND_ENQUEUED, '0, '0);
      end
    end else if (w.operation == rtt_pkg::OP_ACK) begin
      for (i = 0; i < tbl_count && !hit; i++) begin
        if (tbl_sent[i] && tbl_sequence[i] == w.acked_sequence) begin
          tbl_acked[i] = 1'b1;
          hit = 1'b1;
        end
      end
      note_word(hit ? rtt_pkg::KIND_ACK_HIT : rtt_pkg::KIND_ACK_MISS, '0, '0);
    end else if (w.operation == rtt_pkg::OP_TICK && w.round_trip_ms != 0) begin
      i = 0;
      while (i < tbl_count) begin
        lhs = 32'(tbl_elapsed[i]) * 32'd16;
        rhs = 32'(w.round_trip_ms) * 32'(tbl_factor[i]);
        if (lhs > rhs) begin
          tbl_elapsed[i] = '0;
          tbl_sequence[i] = seq_counter;
          seq_counter = seq_counter + 16'd1;
          tbl_sent[i] = 1'b1;
          tbl_acked[i] = 1'b0;
          note_word(rtt_pkg::KIND_RESEND, tbl_handle[i], tbl_sequence[i]);
        end else if (tbl_acked[i]) begin
          // Removal: the last entry moves into this slot and is handled next.
          tbl_count--;
          tbl_handle[i] = tbl_handle[tbl_count];
          tbl_elapsed[i] = tbl_elapsed[tbl_count];
          tbl_factor[i] = tbl_factor[tbl_count];
          tbl_sequence[i] = tbl_sequence[tbl_count];
          tbl_acked[i] = tbl_acked[tbl_count];
          tbl_sent[i] = tbl_sent[tbl_count];
          continue;
        end
        sum = 17'(tbl_elapsed[i]) + 17'(w.elapsed_ms);
        tbl_elapsed[i] = sum[16] ? rtt_pkg::TIMER_SAT : sum[15:0];
        i++;
      end
      note_word(rtt_pkg::KIND_TICK_DONE, '0, '0);
    end else begin
      // An unknown round trip time or an unknown operation changes nothing.
      note_word(rtt_pkg::KIND_TICK_DONE, '0, '0);
    end
    expected_words[$].last = 1'b1;
  endfunction

  // One row of the directed table: a word and, where it is obvious, the
  // expected kind and count of its final result.
  typedef struct {
    rtt_pkg::in_word_t word;
    bit                typed;
    logic [2:0]        kind;
    logic [5:0]        count;
  } directed_row_t;

  directed_row_t directed_rows [$];

  function automatic rtt_pkg::in_word_t make_word(logic [1:0] op, logic [15:0] handle,
                                                  logic [7:0] factor, logic [15:0] delta,
                                                  logic [15:0] rtt, logic [15:0] aseq);
    rtt_pkg::in_word_t w;
    w.operation = op;
    w.message_handle = handle;
    w.timeout_factor = factor;
    w.elapsed_ms = delta;
    w.round_trip_ms = rtt;
    w.acked_sequence = aseq;
    return w;
  endfunction

  function automatic void add_row(rtt_pkg::in_word_t w, bit typed, logic [2:0] kind,
                                  logic [5:0] count);
    directed_row_t r;
    r.word = w;
    r.typed = typed;
    r.kind = kind;
    r.count = count;
    directed_rows.push_back(r);
  endfunction

  // Mostly well-formed traffic: enqueues, also into a full table, acks that often name
  // a sequence recently handed out, and ticks that often carry a known round trip time.
  function automatic rtt_pkg::in_word_t random_word();
    rtt_pkg::in_word_t w;
    int pick;
    w = rtt_pkg::in_word_t'($bits(rtt_pkg::in_word_t)'({$urandom, $urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      w.operation = rtt_pkg::OP_ENQUEUE;
      if ($urandom_range(0, 3) != 0) w.timeout_factor = 8'($urandom_range(0, 40));
    end else if (pick < 60) begin
      w.operation = rtt_pkg::OP_ACK;
      if ($urandom_range(0, 4) != 0 && seq_counter != 0)
        w.acked_sequence = seq_counter - 16'($urandom_range(1, 40));
    end else if (pick < 97) begin
      w.operation = rtt_pkg::OP_TICK;
      if ($urandom_range(0, 3) != 0) begin
        w.round_trip_ms = 16'($urandom_range(1, 300));
        w.elapsed_ms = 16'($urandom_range(0, 2000));
      end
      if ($urandom_range(0, 15) == 0) w.round_trip_ms = '0;
    end else begin
      w.operation = OP_UNKNOWN;
    end
    return w;
  endfunction

  // Sender: one word at a time, with a random gap before each. push_i is
  // dropped only when a gap follows, so it gets one update per clock edge.
  task automatic send_word(rtt_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    predict_table(w);
  endtask

  initial begin
    int n;
    rtt_pkg::in_word_t w;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: exercise acks before any send, the unknown round trip time,
    // resends, matching acks, removal on the next tick and an unknown operation,
    // then fill the table to the top and past it.
    add_row(make_word(rtt_pkg::OP_ACK, 16'h0, 8'h0, 16'h0, 16'h0, 16'h0), 1,
            rtt_pkg::KIND_ACK_MISS, 6'd0);
    add_row(make_word(rtt_pkg::OP_TICK, 16'h0, 8'h0, 16'hFFFF, 16'h0, 16'h0), 1,
            rtt_pkg::KIND_TICK_DONE, 6'd0);
    add_row(make_word(rtt_pkg::OP_ENQUEUE, 16'hFFFF, 8'hFF, 16'h0, 16'h0, 16'h0), 1,
            rtt_pkg::KIND_ENQUEUED, 6'd1);
    add_row(make_word(rtt_pkg::OP_ENQUEUE, 16'h0000, 8'h00, 16'h0, 16'h0, 16'h0), 1,
            rtt_pkg::KIND_ENQUEUED, 6'd2);
    add_row(make_word(rtt_pkg::OP_ACK, 16'h0, 8'h0, 16'h0, 16'h0, 16'h0), 1,
            rtt_pkg::KIND_ACK_MISS, 6'd2);
    add_row(make_word(rtt_pkg::OP_TICK, 16'h0, 8'h0, 16'hFFFF, 16'h0, 16'h0), 1,
            rtt_pkg::KIND_TICK_DONE, 6'd2);
    // The largest factor times the largest rtt still loses to a saturated timer
    // only if 65535*16 exceeds it, which it does not; the zero factor resends.
    add_row(make_word(rtt_pkg::OP_TICK, 16'h0, 8'h0, 16'hFFFF, 16'hFFFF, 16'h0), 0, '0, '0);
    add_row(make_word(rtt_pkg::OP_TICK, 16'h0, 8'h0, 16'h0001, 16'h0001, 16'h0), 0, '0, '0);
    add_row(make_word(rtt_pkg::OP_ACK, 16'h0, 8'h0, 16'h0, 16'h0, 16'h0001), 1,
            rtt_pkg::KIND_ACK_HIT, 6'd2);
    add_row(make_word(rtt_pkg::OP_ACK, 16'h0, 8'h0, 16'h0, 16'h0, 16'hFFFF), 1,
            rtt_pkg::KIND_ACK_MISS, 6'd2);
    add_row(make_word(rtt_pkg::OP_TICK, 16'h0, 8'h0, 16'h0000, 16'hFFFF, 16'h0), 0, '0, '0);
    add_row(make_word(OP_UNKNOWN, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
            rtt_pkg::KIND_TICK_DONE, 6'd1);
    for (n = 0; n < ENTRIES + 1; n++)
      add_row(make_word(rtt_pkg::OP_ENQUEUE, 16'(n * 997), 8'(n * 8), 16'h0, 16'h0, 16'h0),
              0, '0, '0);
    add_row(make_word(rtt_pkg::OP_TICK, 16'h0, 8'h0, 16'hFFFF, 16'h0080, 16'h0), 0, '0, '0);

    foreach (directed_rows[k]) begin
      send_word(directed_rows[k].word);
      // Typed expectations must agree with the predictor's final word.
      if (directed_rows[k].typed &&
          (expected_words[$].kind !== directed_rows[k].kind ||
           expected_words[$].pending_count !== directed_rows[k].count)) begin
        $display("%0t: directed row %0d expected kind %0d count %0d, predictor %0d %0d",
                 $time, k, directed_rows[k].kind, directed_rows[k].count,
                 expected_words[$].kind, expected_words[$].pending_count);
        failures++;
      end
    end

    for (n = 0; n < RANDOM_WORDS; n++) begin
      // Once midway the sender holds off until the result side has drained.
      if (n == RANDOM_WORDS / 2) begin
        push_i <= 1'b0;
        wait (expected_words.size() == 0);
        @(posedge clk_i);
      end
      w = random_word();
      send_word(w);
    end
    push_i <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: draws a stall before each word, then pops it and checks it.
  // pop_i is dropped only when a stall follows.
  initial begin
    int stall;
    rtt_pkg::out_word_t exp_w;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 8);
      if (stall > 0) begin
        pop_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      @(posedge clk_i);
      while (empty_o) @(posedge clk_i);
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, out_word_o);
        failures++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word_o !== exp_w) begin
          $display("%0t: word mismatch, expected %p, actual %p", $time, exp_w, out_word_o);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // End of run: all sent, all results back, then a short drain for strays.
  initial begin
    wait (sender_done && expected_words.size() == 0);
    repeat (4 * ENTRIES) @(posedge clk_i);
    if (failures == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rtt_pkg.sv
rtl/rtt_front.sv
rtl/rtt_engine.sv
rtl/retransmit_timer_table_unit.sv
sim/retransmit_timer_table_unit_test.sv
